// File: design/lpcio_pkg.sv
package lpcio_pkg;

  // Event codes on the input channel.
  localparam logic [2:0] OP_FRAME_START = 3'd0;
  localparam logic [2:0] OP_FRAME_END   = 3'd1;
  localparam logic [2:0] OP_CLOCK       = 3'd2;
  localparam logic [2:0] OP_POP         = 3'd3;
  localparam logic [2:0] OP_CLEAR       = 3'd4;

  localparam logic [3:0] MAX_KIND = 4'd5;

  localparam logic [15:0] TPM_CFG_LO  = 16'h004E;
  localparam logic [15:0] TPM_CFG_HI  = 16'h004F;
  localparam logic [15:0] TPM_IO_LO   = 16'h0020;
  localparam logic [15:0] TPM_IO_HI   = 16'h002F;

  // One captured cycle as held in the ring, 61 bits.
  typedef struct packed {
    logic        is_read;
    logic [15:0] address;
    logic [7:0]  data;
    logic [2:0]  kind;
    logic [31:0] stamp;
    logic        tpm;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // What the cycle decoder tells the ring controller in the current cycle.
  typedef struct packed {
    logic        store;
    logic        bad_kind;
    logic        is_read;
    logic [15:0] address;
    logic [7:0]  data;
    logic [2:0]  kind;
    logic        tpm;
  } dec_evt_t;

  function automatic logic tpm_hit(input logic [15:0] a);
    tpm_hit = (a == TPM_CFG_LO) || (a == TPM_CFG_HI) ||
              ((a >= TPM_IO_LO) && (a <= TPM_IO_HI));
  endfunction

endpackage

// File: design/lpcio_if.sv
interface lpcio_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [3:0]  lad_nibble;
  logic [31:0] time_stamp;

  modport source (output valid, opcode, lad_nibble, time_stamp, input ready);
  modport sink   (input valid, opcode, lad_nibble, time_stamp, output ready);
endinterface

interface lpcio_cap_if;
  logic        valid;
  logic        ready;
  logic        entry_valid;
  logic        is_read;
  logic [15:0] cycle_address;
  logic [7:0]  cycle_data;
  logic [2:0]  cycle_kind;
  logic [31:0] cycle_time;
  logic        in_tpm_range;
  logic [31:0] total_count;
  logic [31:0] tpm_count;
  logic [31:0] error_count;

  modport source (output valid, entry_valid, is_read, cycle_address, cycle_data,
                  cycle_kind, cycle_time, in_tpm_range, total_count, tpm_count,
                  error_count, input ready);
  modport sink   (input valid, entry_valid, is_read, cycle_address, cycle_data,
                  cycle_kind, cycle_time, in_tpm_range, total_count, tpm_count,
                  error_count, output ready);
endinterface

// File: design/lpcio_ram.sv
module lpcio_ram #(
  parameter int WIDTH = 61,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/lpcio_decode.sv
module lpcio_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [2:0]        opcode,
  input  logic [3:0]        lad_nibble,
  output lpcio_pkg::dec_evt_t dec
);
  import lpcio_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_ADDR  = 3'd2;
  localparam logic [2:0] PH_WDATA = 3'd3;
  localparam logic [2:0] PH_RDATA = 3'd4;

  logic [2:0]  phase;
  logic [2:0]  nib_idx;
  logic [2:0]  nib_idx_next;
  logic [15:0] addr_shift;
  logic [7:0]  data_shift;
  logic [2:0]  kind_reg;
  logic        read_flag;
  logic        in_data;

  assign in_data      = (phase == PH_WDATA) || (phase == PH_RDATA);
  assign nib_idx_next = nib_idx + 3'd1;

  assign dec.store    = fire && (opcode == OP_FRAME_END) && in_data;
  assign dec.bad_kind = fire && (opcode == OP_CLOCK) && (phase == PH_START) &&
                        (lad_nibble > MAX_KIND);
  assign dec.is_read  = read_flag;
  assign dec.address  = addr_shift;
  assign dec.data     = data_shift;
  assign dec.kind     = kind_reg;
  assign dec.tpm      = tpm_hit(addr_shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      nib_idx    <= '0;
      addr_shift <= '0;
      data_shift <= '0;
      kind_reg   <= '0;
      read_flag  <= 1'b0;
    end else if (fire) begin
      unique case (opcode)
        OP_FRAME_START: begin
          phase      <= PH_START;
          nib_idx    <= '0;
          addr_shift <= '0;
          data_shift <= '0;
          kind_reg   <= '0;
        end
        OP_FRAME_END: begin
          phase <= PH_IDLE;
        end
        OP_CLOCK: begin
          unique case (phase)
            PH_START: begin
              if (lad_nibble > MAX_KIND) begin
                phase <= PH_IDLE;
              end else begin
                kind_reg  <= lad_nibble[2:0];
                read_flag <= ~lad_nibble[0];
                phase     <= PH_ADDR;
                nib_idx   <= 3'd1;
              end
            end
            PH_ADDR: begin
              addr_shift <= {addr_shift[11:0], lad_nibble};
              nib_idx    <= nib_idx_next;
              if (nib_idx_next == 3'd5) begin
                phase <= read_flag ? PH_RDATA : PH_WDATA;
              end
            end
            PH_WDATA, PH_RDATA: begin
              data_shift <= {data_shift[3:0], lad_nibble};
              nib_idx    <= nib_idx_next;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/lpcio_ring.sv
module lpcio_ring #(
  parameter int RING_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [2:0]          opcode,
  input  logic [31:0]         time_stamp,
  input  lpcio_pkg::dec_evt_t dec,
  output logic                in_ready,
  lpcio_cap_if.source         cap
);
  import lpcio_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] tail_inc;
  logic          empty;
  logic          full;
  logic          wr_en;
  logic          do_pop;
  logic          rd_en;
  logic          clr;
  slot_t         wr_slot;
  slot_t         rd_slot;
  logic [SLOT_W-1:0] rd_bits;

  logic [31:0] total_cnt;
  logic [31:0] tpm_cnt;
  logic [31:0] err_cnt;

  // Read stage: a pop waiting for its memory data.
  logic        s1_valid;
  logic        s1_hit;
  logic [31:0] s1_total;
  logic [31:0] s1_tpm;
  logic [31:0] s1_err;
  logic        s1_move;

  logic        out_valid;

  assign head_inc = (head == LAST) ? '0 : head + 1'b1;
  assign tail_inc = (tail == LAST) ? '0 : tail + 1'b1;
  assign empty    = (head == tail);
  assign full     = (head_inc == tail);

  assign wr_en  = dec.store && !full;
  assign do_pop = fire && (opcode == OP_POP);
  assign rd_en  = do_pop && !empty;
  assign clr    = fire && (opcode == OP_CLEAR);

  assign wr_slot.is_read = dec.is_read;
  assign wr_slot.address = dec.address;
  assign wr_slot.data    = dec.data;
  assign wr_slot.kind    = dec.kind;
  assign wr_slot.stamp   = time_stamp;
  assign wr_slot.tpm     = dec.tpm;
  assign rd_slot         = slot_t'(rd_bits);

  lpcio_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (head),
    .wr_data (wr_slot),
    .rd_en   (rd_en),
    .rd_addr (tail),
    .rd_data (rd_bits)
  );

  assign s1_move  = s1_valid && (!out_valid || cap.ready);
  assign in_ready = !(s1_valid && out_valid && !cap.ready);
  assign cap.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      total_cnt <= '0;
      tpm_cnt   <= '0;
      err_cnt   <= '0;
    end else begin
      if (wr_en) begin
        head <= head_inc;
      end
      if (rd_en) begin
        tail <= tail_inc;
      end
      if (clr) begin
        total_cnt <= '0;
        tpm_cnt   <= '0;
        err_cnt   <= '0;
      end else begin
        if (wr_en) begin
          total_cnt <= total_cnt + 32'd1;
          tpm_cnt   <= tpm_cnt + {31'd0, dec.tpm};
        end
        if (dec.bad_kind || (dec.store && full)) begin
          err_cnt <= err_cnt + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (do_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_valid && cap.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      s1_hit   <= !empty;
      s1_total <= total_cnt;
      s1_tpm   <= tpm_cnt;
      s1_err   <= err_cnt;
    end
    if (s1_move) begin
      cap.entry_valid   <= s1_hit;
      cap.is_read       <= s1_hit && rd_slot.is_read;
      cap.cycle_address <= s1_hit ? rd_slot.address : '0;
      cap.cycle_data    <= s1_hit ? rd_slot.data : '0;
      cap.cycle_kind    <= s1_hit ? rd_slot.kind : '0;
      cap.cycle_time    <= s1_hit ? rd_slot.stamp : '0;
      cap.in_tpm_range  <= s1_hit && rd_slot.tpm;
      cap.total_count   <= s1_total;
      cap.tpm_count     <= s1_tpm;
      cap.error_count   <= s1_err;
    end
  end

`ifndef SYNTH
  a_store_fills: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> head != tail)
    else $error("ring empty right after a stored cycle");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    clr |=> (total_cnt == 32'd0) && (tpm_cnt == 32'd0) && (err_cnt == 32'd0))
    else $error("counters not zero after a clear");

  a_tpm_with_total: assert property (@(posedge clk) disable iff (rst)
    (tpm_cnt != $past(tpm_cnt)) |-> (total_cnt != $past(total_cnt)) || $past(clr))
    else $error("TPM count moved without the total count");
`endif

endmodule

// File: design/lpc_io_cycle_capture.sv
// LPC I/O cycle capture.
// Input channel evt: one bus event per transaction (frame start, frame end,
// LAD nibble, pop, clear statistics) with the LAD nibble and a timestamp.
// Output channel cap: one transaction per accepted pop, carrying the oldest
// stored cycle (or entry_valid low when the ring is empty) and the three
// statistics counters as they stood when the pop was accepted.
// Throughput is one event per clock while evt.ready is high. Decoding, ring
// stores and counter updates take effect in the cycle an event is accepted;
// a pop result passes through the synchronous read of the ring memory and
// then the output register before it shows on cap.
// When the receiver stalls, one popped result waits in the output register
// and a second in the read stage; evt.ready then drops until cap moves.
// Reset empties the ring by clearing its head and tail pointers, clears the
// counters and the decoder; the ring memory itself is not swept, so the
// block accepts events as soon as reset is released.
module lpc_io_cycle_capture #(
  parameter int RING_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  lpcio_evt_if.sink   evt,
  lpcio_cap_if.source cap
);
  import lpcio_pkg::*;

  logic     fire;
  logic     in_ready;
  dec_evt_t dec;

  // A transaction on evt moves whenever both sides agree.
  assign fire      = evt.valid && in_ready;
  assign evt.ready = in_ready;

  // Cycle decoder: follows the frame, type, address and data phases.
  lpcio_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .opcode     (evt.opcode),
    .lad_nibble (evt.lad_nibble),
    .dec        (dec)
  );

  // Ring controller: stores finished cycles, serves pops, keeps the counters.
  lpcio_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .opcode     (evt.opcode),
    .time_stamp (evt.time_stamp),
    .dec        (dec),
    .in_ready   (in_ready),
    .cap        (cap)
  );

endmodule

// File: sim/lpc_cycle_checker.sv
module lpc_cycle_checker #(
  parameter int RING_DEPTH = 64
) (
  input  logic  clk,
  input  logic  rst,
  lpcio_evt_if  evt,
  lpcio_cap_if  cap,
  output int    fails,
  output int    pending
);
  import lpcio_pkg::*;

  typedef enum logic [2:0] {
    BUS_IDLE,
    BUS_KIND,
    BUS_ADDR,
    BUS_WDATA,
    BUS_RDATA
  } bus_phase_t;

  typedef struct packed {
    logic        entry_valid;
    slot_t       entry;
    logic [31:0] total;
    logic [31:0] tpm;
    logic [31:0] errors;
  } pop_result_t;

  // Decoder state as the bus has driven it so far.
  bus_phase_t  bus_phase;
  logic [2:0]  nib_count;
  logic [15:0] addr_sr;
  logic [7:0]  data_sr;
  logic [2:0]  kind_r;
  logic        rd_r;

  // The ring holds at most RING_DEPTH-1 entries, oldest first.
  slot_t       captured[$];
  logic [31:0] stored_total;
  logic [31:0] stored_tpm;
  logic [31:0] fault_count;

  pop_result_t owed_pops[$];
  int          fail_tally = 0;

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
      fail_tally++;
    end
  endfunction

  always @(posedge clk) begin
    pop_result_t due;
    pop_result_t owed;
    slot_t       fresh;
    if (rst) begin
      bus_phase    = BUS_IDLE;
      nib_count    = '0;
      addr_sr      = '0;
      data_sr      = '0;
      kind_r       = '0;
      rd_r         = 1'b0;
      stored_total = '0;
      stored_tpm   = '0;
      fault_count  = '0;
      captured.delete();
      owed_pops.delete();
    end else begin
      if (cap.valid && cap.ready) begin
        if (owed_pops.size() == 0) begin
          $display("%0t: capture transaction with no pop outstanding", $time);
          fail_tally++;
        end else begin
          due = owed_pops.pop_front();
          check_field("entry_valid", 32'(due.entry_valid), 32'(cap.entry_valid));
          check_field("is_read", 32'(due.entry.is_read), 32'(cap.is_read));
          check_field("cycle_address", 32'(due.entry.address), 32'(cap.cycle_address));
          check_field("cycle_data", 32'(due.entry.data), 32'(cap.cycle_data));
          check_field("cycle_kind", 32'(due.entry.kind), 32'(cap.cycle_kind));
          check_field("cycle_time", due.entry.stamp, cap.cycle_time);
          check_field("in_tpm_range", 32'(due.entry.tpm), 32'(cap.in_tpm_range));
          check_field("total_count", due.total, cap.total_count);
          check_field("tpm_count", due.tpm, cap.tpm_count);
          check_field("error_count", due.errors, cap.error_count);
        end
      end

      if (evt.valid && evt.ready) begin
        case (evt.opcode)
          OP_FRAME_START: begin
            // The read flag survives a restart until the next type nibble.
            bus_phase = BUS_KIND;
            nib_count = '0;
            addr_sr   = '0;
            data_sr   = '0;
            kind_r    = '0;
          end
          OP_FRAME_END: begin
            if (bus_phase == BUS_WDATA || bus_phase == BUS_RDATA) begin
              if (captured.size() == RING_DEPTH - 1) begin
                fault_count++;
              end else begin
                fresh.is_read = rd_r;
                fresh.address = addr_sr;
                fresh.data    = data_sr;
                fresh.kind    = kind_r;
                fresh.stamp   = evt.time_stamp;
                fresh.tpm     = (addr_sr[15:4] == 12'h002) || (addr_sr[15:1] == 15'h0027);
                captured.push_back(fresh);
                stored_total++;
                if (fresh.tpm) stored_tpm++;
              end
            end
            bus_phase = BUS_IDLE;
          end
          OP_CLOCK: begin
            case (bus_phase)
              BUS_KIND: begin
                if (evt.lad_nibble > MAX_KIND) begin
                  fault_count++;
                  bus_phase = BUS_IDLE;
                end else begin
                  kind_r    = evt.lad_nibble[2:0];
                  rd_r      = ~evt.lad_nibble[0];
                  bus_phase = BUS_ADDR;
                  nib_count = 3'd1;
                end
              end
              BUS_ADDR: begin
                addr_sr   = {addr_sr[11:0], evt.lad_nibble};
                nib_count = nib_count + 3'd1;
                if (nib_count == 3'd5) bus_phase = rd_r ? BUS_RDATA : BUS_WDATA;
              end
              BUS_WDATA, BUS_RDATA: begin
                data_sr   = {data_sr[3:0], evt.lad_nibble};
                nib_count = nib_count + 3'd1;
              end
              default: ;
            endcase
          end
          OP_POP: begin
            owed = '0;
            if (captured.size() != 0) begin
              owed.entry_valid = 1'b1;
              owed.entry       = captured.pop_front();
            end
            owed.total  = stored_total;
            owed.tpm    = stored_tpm;
            owed.errors = fault_count;
            owed_pops.push_back(owed);
          end
          OP_CLEAR: begin
            stored_total = '0;
            stored_tpm   = '0;
            fault_count  = '0;
          end
          default: ;
        endcase
      end
    end
    pending <= owed_pops.size();
    fails   <= fail_tally;
  end

endmodule

// File: sim/lpc_io_cycle_capture_tb.sv
module lpc_io_cycle_capture_tb;
  import lpcio_pkg::*;

  localparam int RING_DEPTH  = 64;
  // The limit leaves a wide margin over what a correct run needs.
  localparam int CYCLE_LIMIT = 200_000;
  // Opcode that the block ignores, used to check that nothing happens.
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  logic clk;
  logic rst;
  logic steady;
  int   fails;
  int   pending;
  int   sent;
  int   cycle_count = 0;

  lpcio_evt_if evt_bus ();
  lpcio_cap_if cap_bus ();

  lpc_io_cycle_capture #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .evt (evt_bus),
    .cap (cap_bus)
  );

  lpc_cycle_checker #(.RING_DEPTH(RING_DEPTH)) checker_i (
    .clk     (clk),
    .rst     (rst),
    .evt     (evt_bus),
    .cap     (cap_bus),
    .fails   (fails),
    .pending (pending)
  );

  always #5 clk = ~clk;

  // The receiver stalls about a third of the time, except during the steady
  // stretch where it takes every capture transaction at once.
  always @(posedge clk) begin
    cap_bus.ready <= !rst && (steady || ($urandom_range(99) >= 34));
  end

  // A hung handshake must not keep the run alive forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offers one event and returns at the edge where it is accepted. Outside
  // the steady stretch random idle cycles come first, so gaps land between
  // any two events of a bus cycle. Valid is only lowered when an idle cycle
  // is chosen, never raised and lowered in the same step.
  task automatic send(input logic [2:0] op, input logic [3:0] nib, input logic [31:0] ts);
    while (!steady && ($urandom_range(99) < 34)) begin
      evt_bus.valid <= 1'b0;
      @(posedge clk);
    end
    evt_bus.valid      <= 1'b1;
    evt_bus.opcode     <= op;
    evt_bus.lad_nibble <= nib;
    evt_bus.time_stamp <= ts;
    do @(posedge clk); while (!evt_bus.ready);
    if (op <= OP_CLEAR) sent++;
  endtask

  // Stops offering events and waits until every pop has been answered. The
  // checker's pending count is registered, so the task waits on the clock
  // before it first reads it.
  task automatic drain();
    evt_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // One LPC I/O cycle with random content. Most are well formed; a few carry
  // a bad type nibble, end before the address is complete, restart in the
  // middle, run a long data phase, or never see their frame end.
  task automatic lpc_cycle();
    logic [3:0]  kind;
    logic [15:0] addr;
    int          cut;
    int          ndata;
    int          roll;
    roll = $urandom_range(99);
    kind = (roll < 8) ? 4'($urandom_range(15, 6)) : 4'($urandom_range(5, 0));
    roll = $urandom_range(99);
    if (roll < 10)      addr = 16'h004E + 16'($urandom_range(1));
    else if (roll < 25) addr = 16'h0020 + 16'($urandom_range(15));
    else if (roll < 32) begin
      // Addresses just outside the TPM windows.
      case ($urandom_range(3))
        0:       addr = 16'h001F;
        1:       addr = 16'h0030;
        2:       addr = 16'h004D;
        default: addr = 16'h0050;
      endcase
    end else            addr = 16'($urandom);
    cut   = ($urandom_range(14) == 0) ? $urandom_range(3) : 4;
    ndata = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(4);

    send(OP_FRAME_START, 4'($urandom), $urandom);
    if ($urandom_range(19) == 0) begin
      // A cycle cut short by a new frame start.
      send(OP_CLOCK, 4'($urandom_range(5)), $urandom);
      send(OP_CLOCK, 4'($urandom), $urandom);
      send(OP_FRAME_START, 4'($urandom), $urandom);
    end
    send(OP_CLOCK, kind, $urandom);
    for (int i = 0; i < cut; i++) send(OP_CLOCK, addr[15 - 4 * i -: 4], $urandom);
    if (cut == 4) begin
      for (int i = 0; i < ndata; i++) send(OP_CLOCK, 4'($urandom), $urandom);
    end
    if ($urandom_range(19) != 0) send(OP_FRAME_END, 4'($urandom), $urandom);
  endtask

  // Bus cycles mixed with pops, statistics clears and stray events, until the
  // running event count reaches the given mark.
  task automatic mixed_traffic(input int mark);
    int roll;
    while (sent < mark) begin
      roll = $urandom_range(99);
      if (roll < 55)      lpc_cycle();
      else if (roll < 88) send(OP_POP, 4'($urandom), $urandom);
      else if (roll < 91) send(OP_CLEAR, 4'($urandom), $urandom);
      else if (roll < 96) send(OP_CLOCK, 4'($urandom), $urandom);
      else                send(3'($urandom_range(7, 5)), 4'($urandom), $urandom);
    end
  endtask

  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    steady             = 1'b0;
    sent               = 0;
    evt_bus.valid      = 1'b0;
    evt_bus.opcode     = OP_FRAME_START;
    evt_bus.lad_nibble = 4'h0;
    evt_bus.time_stamp = 32'h0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A pop on the empty ring, then events the block must
    // ignore: a nibble with no frame open and an unused opcode.
    send(OP_POP, 4'hF, 32'hFFFF_FFFF);
    send(OP_CLOCK, 4'h0, 32'h0);
    send(OP_UNUSED_HI, 4'hF, 32'hFFFF_FFFF);
    // A type nibble above the legal range counts an error.
    send(OP_FRAME_START, 4'h0, 32'h0);
    send(OP_CLOCK, 4'hF, 32'h0);
    // A write cycle interrupted by a frame start, then a complete write to
    // the top address with the largest timestamp.
    send(OP_FRAME_START, 4'h0, 32'h0);
    send(OP_CLOCK, 4'h1, 32'h0);
    send(OP_CLOCK, 4'h2, 32'h0);
    send(OP_CLOCK, 4'hF, 32'h0);
    send(OP_FRAME_START, 4'h0, 32'h0);
    send(OP_CLOCK, 4'h3, 32'h0);
    repeat (4) send(OP_CLOCK, 4'hF, 32'h0);
    send(OP_CLOCK, 4'hA, 32'h0);
    send(OP_CLOCK, 4'h5, 32'h0);
    send(OP_FRAME_END, 4'h0, 32'hFFFF_FFFF);
    // A frame end before the address is complete stores nothing.
    send(OP_FRAME_START, 4'h0, 32'h0);
    send(OP_CLOCK, 4'h0, 32'h0);
    send(OP_CLOCK, 4'h0, 32'h0);
    send(OP_FRAME_END, 4'h0, 32'h0);
    // Read back the stored write, clear the counters, pop the empty ring.
    send(OP_POP, 4'h0, 32'h0);
    send(OP_CLEAR, 4'h0, 32'h0);
    send(OP_POP, 4'h0, 32'h0);

    // Fill the ring past capacity with no pops so overflows are counted,
    // then pop it dry and a little beyond.
    repeat (100) lpc_cycle();
    repeat (66) send(OP_POP, 4'($urandom), $urandom);
    drain();

    // A stretch where neither side ever idles.
    steady = 1'b1;
    mixed_traffic(sent + 150);
    steady = 1'b0;

    mixed_traffic(1100);
    drain();
    repeat (8) @(posedge clk);

    if (fails == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
